@@ hdl/skt_pkg.sv @@
// Package for the sorted key table: request and result types, operation and status codes,
// and the command and status bundles between the controller and the datapath.
// Depends on nothing; the controller, datapath and top level use it (skt_ram does not).
package skt_pkg;

    localparam int unsigned OP_W      = 3;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned KEY_W     = 31;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned ENTRY_W   = KEY_W + PAYLOAD_W;

    // Operation codes carried in the request.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_SEARCH    = 3'd2,
        OP_LIST_ASC  = 3'd3,
        OP_LIST_DESC = 3'd4
    } op_t;

    // Status codes carried in each result.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_DUP       = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_EMPTY     = 3'd3,
        STATUS_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [KEY_W-1:0]     out_key;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 last;
    } out_item_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESP
    } state_t;

    // Which address the table read port uses.
    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1,
        RD_LIST
    } rd_sel_t;

    // Where the key and payload of a result come from.
    typedef enum logic [1:0] {
        OUT_ECHO,
        OUT_FOUND,
        OUT_EMPTY,
        OUT_LIST
    } out_sel_t;

    typedef struct packed {
        logic                load_req;
        logic                idx_clr;
        logic                idx_load_cnt;
        logic                idx_inc;
        logic                idx_dec;
        logic                pos_load;
        logic                pos_hit;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        logic                wr_new;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                emit;
        out_sel_t            out_sel;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            cnt_full;
        logic            idx_at_cnt;
        logic            idx_at_pos;
        logic            idx_last;
        logic            key_lt;
        logic            key_eq;
        logic            hit;
        logic            out_free;
    } ctrl_stat_t;

endpackage

@@ hdl/skt_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used by the sorted key table datapath for its record store.
module skt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; the read data holds while re is low.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/skt_ctrl.sv @@
// Controller state machine of the sorted key table.
// Depends on skt_pkg; drives the datapath through the command bundle only.
module skt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  skt_pkg::ctrl_stat_t stat,
    output skt_pkg::ctrl_cmd_t  cmd
);

    skt_pkg::state_t   state_reg, state_next;
    skt_pkg::status_t  resp_status_reg, resp_status_next;
    skt_pkg::out_sel_t resp_sel_reg, resp_sel_next;

    // State and pending response registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= skt_pkg::S_IDLE;
            resp_status_reg <= skt_pkg::STATUS_OK;
            resp_sel_reg    <= skt_pkg::OUT_EMPTY;
        end else begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
            resp_sel_reg    <= resp_sel_next;
        end
    end

    assign s_ready = (state_reg == skt_pkg::S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next       = state_reg;
        resp_status_next = resp_status_reg;
        resp_sel_next    = resp_sel_reg;
        cmd              = '0;
        cmd.rd_sel       = skt_pkg::RD_IDX;
        cmd.out_sel      = skt_pkg::OUT_EMPTY;
        cmd.out_status   = skt_pkg::STATUS_OK;
        case (state_reg)
            skt_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = skt_pkg::S_DISPATCH;
                end
            end
            skt_pkg::S_DISPATCH: begin
                cmd.idx_clr = 1'b1;
                case (stat.op)
                    skt_pkg::OP_INSERT: begin
                        state_next = skt_pkg::S_SCAN_RD;
                    end
                    skt_pkg::OP_DELETE, skt_pkg::OP_SEARCH: begin
                        if (stat.cnt_zero) begin
                            resp_status_next = skt_pkg::STATUS_EMPTY;
                            resp_sel_next    = skt_pkg::OUT_EMPTY;
                            state_next       = skt_pkg::S_RESP;
                        end else begin
                            state_next = skt_pkg::S_SCAN_RD;
                        end
                    end
                    skt_pkg::OP_LIST_ASC, skt_pkg::OP_LIST_DESC: begin
                        if (stat.cnt_zero) begin
                            resp_status_next = skt_pkg::STATUS_EMPTY;
                            resp_sel_next    = skt_pkg::OUT_EMPTY;
                            state_next       = skt_pkg::S_RESP;
                        end else begin
                            state_next = skt_pkg::S_LIST_RD;
                        end
                    end
                    default: begin
                        // Unused operation codes are dropped without a result.
                        state_next = skt_pkg::S_IDLE;
                    end
                endcase
            end
            skt_pkg::S_SCAN_RD: begin
                if (stat.idx_at_cnt) begin
                    cmd.pos_load = 1'b1;
                    cmd.pos_hit  = 1'b0;
                    state_next   = skt_pkg::S_DECIDE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = skt_pkg::RD_IDX;
                    state_next = skt_pkg::S_SCAN_CMP;
                end
            end
            skt_pkg::S_SCAN_CMP: begin
                if (stat.key_lt) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = skt_pkg::S_SCAN_RD;
                end else begin
                    cmd.pos_load = 1'b1;
                    cmd.pos_hit  = stat.key_eq;
                    state_next   = skt_pkg::S_DECIDE;
                end
            end
            skt_pkg::S_DECIDE: begin
                state_next = skt_pkg::S_RESP;
                if (stat.op == skt_pkg::OP_INSERT) begin
                    resp_sel_next = skt_pkg::OUT_ECHO;
                    if (stat.hit) begin
                        resp_status_next = skt_pkg::STATUS_DUP;
                    end else if (stat.cnt_full) begin
                        resp_status_next = skt_pkg::STATUS_FULL;
                    end else begin
                        cmd.idx_load_cnt = 1'b1;
                        state_next       = skt_pkg::S_INS_RD;
                    end
                end else if (stat.hit) begin
                    resp_status_next = skt_pkg::STATUS_OK;
                    resp_sel_next    = skt_pkg::OUT_FOUND;
                end else begin
                    resp_status_next = skt_pkg::STATUS_NOT_FOUND;
                    resp_sel_next    = skt_pkg::OUT_ECHO;
                end
            end
            skt_pkg::S_INS_RD: begin
                if (stat.idx_at_pos) begin
                    // Gap is open: place the new record and report success.
                    cmd.wr_en        = 1'b1;
                    cmd.wr_new       = 1'b1;
                    cmd.cnt_inc      = 1'b1;
                    resp_status_next = skt_pkg::STATUS_OK;
                    resp_sel_next    = skt_pkg::OUT_ECHO;
                    state_next       = skt_pkg::S_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = skt_pkg::RD_IDX_M1;
                    state_next = skt_pkg::S_INS_WR;
                end
            end
            skt_pkg::S_INS_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.idx_dec = 1'b1;
                state_next  = skt_pkg::S_INS_RD;
            end
            skt_pkg::S_DEL_RD: begin
                if (stat.idx_last) begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = skt_pkg::S_IDLE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = skt_pkg::RD_IDX_P1;
                    state_next = skt_pkg::S_DEL_WR;
                end
            end
            skt_pkg::S_DEL_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = skt_pkg::S_DEL_RD;
            end
            skt_pkg::S_LIST_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = skt_pkg::RD_LIST;
                state_next = skt_pkg::S_LIST_OUT;
            end
            skt_pkg::S_LIST_OUT: begin
                if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.out_sel    = skt_pkg::OUT_LIST;
                    cmd.out_status = skt_pkg::STATUS_OK;
                    cmd.out_last   = stat.idx_last;
                    if (stat.idx_last) begin
                        state_next = skt_pkg::S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = skt_pkg::S_LIST_RD;
                    end
                end
            end
            skt_pkg::S_RESP: begin
                if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.out_sel    = resp_sel_reg;
                    cmd.out_status = resp_status_reg;
                    cmd.out_last   = 1'b1;
                    // A successful delete closes the gap after reporting.
                    if (stat.op == skt_pkg::OP_DELETE
                            && resp_status_reg == skt_pkg::STATUS_OK) begin
                        state_next = skt_pkg::S_DEL_RD;
                    end else begin
                        state_next = skt_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/skt_datapath.sv @@
// Datapath of the sorted key table: request registers, walk index, entry count,
// record RAM and result register. Depends on skt_pkg and skt_ram.
module skt_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  skt_pkg::in_item_t   s_data,
    output skt_pkg::out_item_t  m_data,
    output logic                m_valid,
    input  logic                m_ready,
    input  skt_pkg::ctrl_cmd_t  cmd,
    output skt_pkg::ctrl_stat_t stat
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = $clog2(CAPACITY);

    logic [skt_pkg::OP_W-1:0]      op_reg;
    logic [skt_pkg::KEY_W-1:0]     key_reg;
    logic [skt_pkg::PAYLOAD_W-1:0] payload_reg;
    logic [skt_pkg::PAYLOAD_W-1:0] found_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 idx_reg;
    logic [CW-1:0]                 pos_reg;
    logic                          hit_reg;
    logic                          m_valid_reg;
    skt_pkg::out_item_t            m_data_reg;

    logic [CW-1:0]                 rd_idx;
    logic [skt_pkg::ENTRY_W-1:0]   rdata;
    logic [skt_pkg::ENTRY_W-1:0]   wdata;
    logic [skt_pkg::KEY_W-1:0]     rd_key;
    logic [skt_pkg::PAYLOAD_W-1:0] rd_payload;
    skt_pkg::out_item_t            out_next;

    assign rd_key     = rdata[skt_pkg::ENTRY_W-1:skt_pkg::PAYLOAD_W];
    assign rd_payload = rdata[skt_pkg::PAYLOAD_W-1:0];

    // Read address selection.
    always_comb begin
        case (cmd.rd_sel)
            skt_pkg::RD_IDX_M1: rd_idx = idx_reg - CW'(1);
            skt_pkg::RD_IDX_P1: rd_idx = idx_reg + CW'(1);
            skt_pkg::RD_LIST: begin
                if (op_reg == skt_pkg::OP_LIST_DESC) begin
                    rd_idx = cnt_reg - CW'(1) - idx_reg;
                end else begin
                    rd_idx = idx_reg;
                end
            end
            default: rd_idx = idx_reg;
        endcase
    end

    // Writes either place the new record or move the record just read.
    assign wdata = cmd.wr_new ? {key_reg, payload_reg} : rdata;

    skt_ram #(
        .WIDTH(skt_pkg::ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.wr_en),
        .waddr(idx_reg[AW-1:0]),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(rd_idx[AW-1:0]),
        .rdata(rdata)
    );

    // Result fields for the next emitted result.
    always_comb begin
        out_next.status = cmd.out_status;
        out_next.last   = cmd.out_last;
        case (cmd.out_sel)
            skt_pkg::OUT_ECHO: begin
                out_next.out_key     = key_reg;
                out_next.out_payload = '0;
            end
            skt_pkg::OUT_FOUND: begin
                out_next.out_key     = key_reg;
                out_next.out_payload = found_reg;
            end
            skt_pkg::OUT_LIST: begin
                out_next.out_key     = rd_key;
                out_next.out_payload = rd_payload;
            end
            default: begin
                out_next.out_key     = '0;
                out_next.out_payload = '0;
            end
        endcase
    end

    // Control registers: entry count and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request, walk and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg      <= s_data.operation;
            key_reg     <= s_data.key;
            payload_reg <= s_data.payload;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_load_cnt) begin
            idx_reg <= cnt_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (cmd.pos_load) begin
            pos_reg   <= idx_reg;
            hit_reg   <= cmd.pos_hit;
            found_reg <= rd_payload;
        end
        if (cmd.emit) begin
            m_data_reg <= out_next;
        end
    end

    // Status toward the controller.
    always_comb begin
        stat.op         = op_reg;
        stat.cnt_zero   = (cnt_reg == '0);
        stat.cnt_full   = (cnt_reg == CW'(CAPACITY));
        stat.idx_at_cnt = (idx_reg == cnt_reg);
        stat.idx_at_pos = (idx_reg == pos_reg);
        stat.idx_last   = ({1'b0, idx_reg} + (CW + 1)'(1) == {1'b0, cnt_reg});
        stat.key_lt     = (rd_key < key_reg);
        stat.key_eq     = (rd_key == key_reg);
        stat.hit        = hit_reg;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/sorted_key_table_unit.sv @@
// Top level of the sorted key table: controller plus datapath.
// Depends on skt_pkg, skt_ctrl and skt_datapath (which holds skt_ram).
//
// Usage: a request on s_data (operation, key, payload) is taken when s_valid and
// s_ready are high. Results leave on m_data (status, out_key, out_payload, last)
// under m_valid/m_ready; last marks the final result of a request.
// Records are kept in ascending key order in a RAM of CAPACITY entries.
// One request is worked at a time; s_ready is high only while the controller idles.
// Work per request, with n stored records and p the position of the key:
//   search and delete walk the records up to position p; a delete then moves
//   the n - p - 1 records above p down to close the gap; insert walks to its
//   position, then moves the records above it up by one; a listing reads each record.
// Every step of a walk reads one record through the single RAM read port and uses
// it in the following state (for a listing, once the output register is free).
// A result waits in the output register while m_ready is low; the controller
// stalls only when it has a further result to send. The next request may be
// taken while the last result still waits.
// Reset empties the table at once (count cleared); no clearing pass is needed.
module sorted_key_table_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  skt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output skt_pkg::out_item_t m_data
);

    skt_pkg::ctrl_cmd_t  cmd;
    skt_pkg::ctrl_stat_t stat;

    // Sequencing of each request.
    skt_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // Storage, comparison and result register.
    skt_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .m_data (m_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
